@@ rtl/pts_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Path threat scorer package
// Shared widths, pattern tables, register indexes and types.
// ----------------------------------------------------------------------------
package pts_pkg;

   localparam int MAX_PATH  = 256;
   localparam int CNT_W     = $clog2(MAX_PATH);
   localparam int WIN_LEN   = 12;
   localparam int PAT_NUM   = 11;
   localparam int WEIGHT_W  = 7;
   localparam int SCORE_W   = 9;
   localparam int CSR_IDX_W = 8;

   typedef logic [7:0] char_type;
   // Element 0 holds the newest byte, element WIN_LEN-1 the oldest.
   typedef char_type [WIN_LEN-1:0] win_type;

   typedef enum logic [1:0] {
      GRP_SENS,
      GRP_SCRIPT,
      GRP_TEMP
   } grp_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SENSITIVE_WEIGHT = 8'd0,
      REG_ROOT_WEIGHT      = 8'd1,
      REG_SCRIPT_WEIGHT    = 8'd2,
      REG_TEMP_DIR_WEIGHT  = 8'd3
   } reg_idx_type;

   localparam logic [WEIGHT_W-1:0] SENSITIVE_WEIGHT_RST = 7'd50;
   localparam logic [WEIGHT_W-1:0] ROOT_WEIGHT_RST      = 7'd30;
   localparam logic [WEIGHT_W-1:0] SCRIPT_WEIGHT_RST    = 7'd20;
   localparam logic [WEIGHT_W-1:0] TEMP_DIR_WEIGHT_RST  = 7'd15;

   typedef struct packed {
      logic sens;
      logic script;
      logic temp;
   } hits_type;

   // Pattern text is right-aligned: the last character sits in element 0.
   localparam win_type PAT_TEXT [PAT_NUM] = '{
      96'("/etc/passwd"),
      96'("/etc/shadow"),
      96'("/etc/sudoers"),
      96'("/root/"),
      96'("/proc/"),
      96'("/sys/"),
      96'(".sh"),
      96'(".py"),
      96'(".pl"),
      96'("/tmp/"),
      96'("/var/tmp/")
   };

   localparam logic [3:0] PAT_LEN [PAT_NUM] = '{
      4'd11, 4'd11, 4'd12, 4'd6, 4'd6, 4'd5, 4'd3, 4'd3, 4'd3, 4'd5, 4'd9
   };

   localparam grp_type PAT_GROUP [PAT_NUM] = '{
      GRP_SENS, GRP_SENS, GRP_SENS, GRP_SENS, GRP_SENS, GRP_SENS,
      GRP_SCRIPT, GRP_SCRIPT, GRP_SCRIPT,
      GRP_TEMP, GRP_TEMP
   };

endpackage

@@ rtl/pts_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Path threat scorer window cell
// Holds one byte of the window and takes its neighbour's byte on a shift.
// ----------------------------------------------------------------------------
module pts_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              shift,
   input  logic              clear,
   input  pts_pkg::char_type d_in,
   output pts_pkg::char_type q
);

   pts_pkg::char_type data_ff;

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         data_ff <= '0;
      end else if (shift) begin
         data_ff <= d_in;
      end
   end

   assign q = data_ff;

endmodule

@@ rtl/pts_matcher.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Path threat scorer pattern matcher
// Compares the tail of a window against every pattern in parallel.
// ----------------------------------------------------------------------------
module pts_matcher (
   input  pts_pkg::win_type  win,
   output pts_pkg::hits_type hits
);

   always_comb begin
      logic match;
      hits = '0;
      for (int p = 0; p < pts_pkg::PAT_NUM; p++) begin
         match = 1'b1;
         for (int i = 0; i < pts_pkg::WIN_LEN; i++) begin
            if (i < int'(pts_pkg::PAT_LEN[p])) begin
               if (win[i] != pts_pkg::PAT_TEXT[p][i]) begin
                  match = 1'b0;
               end
            end
         end
         if (match) begin
            case (pts_pkg::PAT_GROUP[p])
               pts_pkg::GRP_SENS:   hits.sens   = 1'b1;
               pts_pkg::GRP_SCRIPT: hits.script = 1'b1;
               pts_pkg::GRP_TEMP:   hits.temp   = 1'b1;
               default:             ;
            endcase
         end
      end
   end

endmodule

@@ rtl/path_threat_scorer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Path threat scorer
// Streams a file path one byte per item and scores it for threat patterns.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid / req_ready  req_path_byte, req_caller_uid
//   rsp      out        rsp_valid / rsp_ready  rsp_threat_score, rsp_*_hit
//   csr      in         csr_valid / csr_ready  csr_index, csr_wdata
//
// One item is taken in every cycle while req_ready is high. The new byte and
// the eleven bytes held in the chain of window cells are compared against all
// patterns in the same cycle, so the match logic in front of the cells sets
// that figure. The result for a terminator item is in the output register in
// the cycle after it is taken. Input items stall only while a result is held
// and rsp_ready is low. Synchronous reset restores the default weights and
// clears the window, the sticky flags, the byte count and the result valid flag.
//
module path_threat_scorer (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [7:0]                            req_path_byte,
   input  logic [31:0]                           req_caller_uid,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [pts_pkg::SCORE_W-1:0]           rsp_threat_score,
   output logic                                  rsp_sensitive_hit,
   output logic                                  rsp_script_hit,
   output logic                                  rsp_temp_dir_hit,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [pts_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [pts_pkg::WEIGHT_W-1:0]          csr_wdata
);

   // Weight registers.
   logic [pts_pkg::WEIGHT_W-1:0] sens_w_ff, root_w_ff, script_w_ff, temp_w_ff;

   // Path state.
   logic [pts_pkg::CNT_W-1:0] count_ff, count_in;
   pts_pkg::hits_type         seen_ff, seen_in;
   pts_pkg::hits_type         hits;
   pts_pkg::win_type          win_q, win_next;

   // Output register.
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [pts_pkg::SCORE_W-1:0]   score_ff, score_in;
   pts_pkg::hits_type             rsp_hits_ff;

   logic accept, is_term, take, finish;

   // The configuration port never stalls; writes must come only while idle, which the block does not enforce.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sens_w_ff   <= pts_pkg::SENSITIVE_WEIGHT_RST;
         root_w_ff   <= pts_pkg::ROOT_WEIGHT_RST;
         script_w_ff <= pts_pkg::SCRIPT_WEIGHT_RST;
         temp_w_ff   <= pts_pkg::TEMP_DIR_WEIGHT_RST;
      end else if (csr_valid) begin
         case (csr_index)
            pts_pkg::REG_SENSITIVE_WEIGHT: sens_w_ff   <= csr_wdata;
            pts_pkg::REG_ROOT_WEIGHT:      root_w_ff   <= csr_wdata;
            pts_pkg::REG_SCRIPT_WEIGHT:    script_w_ff <= csr_wdata;
            pts_pkg::REG_TEMP_DIR_WEIGHT:  temp_w_ff   <= csr_wdata;
            default:                       ;
         endcase
      end
   end

   // An item may enter whenever the output register is free or being drained.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign is_term   = (req_path_byte == 8'd0);
   // Bytes past the path length limit are dropped until the terminator.
   assign take      = accept && !is_term &&
                      (count_ff < pts_pkg::CNT_W'(pts_pkg::MAX_PATH - 1));
   assign finish    = accept && is_term;

   // The window as it stands after the new byte has shifted in. Cell 0 takes
   // the incoming byte and each later cell takes the byte of the one before.
   always_comb begin
      win_next[0] = req_path_byte;
      for (int i = 1; i < pts_pkg::WIN_LEN; i++) begin
         win_next[i] = win_q[i-1];
      end
   end

   for (genvar g = 0; g < pts_pkg::WIN_LEN; g++) begin : g_cell
      pts_cell u_cell (
         .clock (clock),
         .reset (reset),
         .shift (take),
         .clear (finish),
         .d_in  (win_next[g]),
         .q     (win_q[g])
      );
   end

   // Patterns are checked against the window with the new byte included. The
   // window starts each path cleared to zero, and no pattern holds a zero
   // byte, so a match can never reach before the start of the path.
   pts_matcher u_matcher (
      .win  (win_next),
      .hits (hits)
   );

   always_comb begin
      seen_in  = seen_ff;
      count_in = count_ff;
      if (finish) begin
         seen_in  = '0;
         count_in = '0;
      end else if (take) begin
         seen_in  = seen_ff | hits;
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff  <= '0;
         count_ff <= '0;
      end else begin
         seen_ff  <= seen_in;
         count_ff <= count_in;
      end
   end

   // Score of the path that the terminator closes.
   always_comb begin
      score_in = '0;
      if (seen_ff.sens) begin
         score_in = score_in + pts_pkg::SCORE_W'(sens_w_ff);
      end
      if (req_caller_uid == 32'd0) begin
         score_in = score_in + pts_pkg::SCORE_W'(root_w_ff);
      end
      if (seen_ff.script) begin
         score_in = score_in + pts_pkg::SCORE_W'(script_w_ff);
      end
      if (seen_ff.temp) begin
         score_in = score_in + pts_pkg::SCORE_W'(temp_w_ff);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         score_ff    <= score_in;
         rsp_hits_ff <= seen_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_threat_score  = score_ff;
   assign rsp_sensitive_hit = rsp_hits_ff.sens;
   assign rsp_script_hit    = rsp_hits_ff.script;
   assign rsp_temp_dir_hit  = rsp_hits_ff.temp;

endmodule

@@ rtl/pts_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Path threat scorer checker
// Port-level assertions on the scorer, bound to the top level.
// ----------------------------------------------------------------------------
module pts_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [7:0]                    req_path_byte,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [pts_pkg::SCORE_W-1:0]   rsp_threat_score,
   input logic                          rsp_sensitive_hit,
   input logic                          rsp_script_hit,
   input logic                          rsp_temp_dir_hit
);

   // A held result keeps its value until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_threat_score) &&
      $stable(rsp_sensitive_hit) && $stable(rsp_script_hit) && $stable(rsp_temp_dir_hit))
      else $error("result changed while stalled");

   // A terminator always produces a result in the next cycle.
   a_term_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_path_byte == 8'd0 |=> rsp_valid)
      else $error("terminator gave no result");

   // A non-zero byte never produces a result.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_path_byte != 8'd0 && (!rsp_valid || rsp_ready)
      |=> !rsp_valid)
      else $error("result without terminator");

   // The input side is never stalled while no result is held.
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

   // Four weights of at most 127 bound the score.
   a_score_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_threat_score <= 9'd508)
      else $error("score out of range");

endmodule

bind path_threat_scorer pts_checker u_pts_checker (.*);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Path threat scorer testbench
// Streams file paths into the scorer one byte per item and checks every score
// against a cycle-free model that tracks the byte window and sticky flags.
// ----------------------------------------------------------------------------
module tb_top;

   // Timing and run length.
   localparam int HALF_PERIOD  = 10;
   localparam int RESET_CYCLES = 6;
   localparam int DRAIN_CYCLES = 8;
   localparam int LONG_HOLD    = 600;
   localparam int CYCLE_LIMIT  = 300000;

   // The scorer only matches the first PATH_LIMIT - 1 bytes of a path.
   localparam int PATH_LIMIT = pts_pkg::MAX_PATH;
   localparam int TAIL_LEN   = pts_pkg::WIN_LEN;
   // Length of a long path and where its ignored temporary directory sits.
   localparam int LONG_LEN   = PATH_LIMIT + 14;
   localparam int TAIL_AT    = PATH_LIMIT + 6;

   // Register indexes that decode to nothing; writes to them must be dropped.
   localparam logic [pts_pkg::CSR_IDX_W-1:0] REG_UNUSED_LOW = 8'h04;
   localparam logic [pts_pkg::CSR_IDX_W-1:0] REG_UNUSED_ALL = 8'hFF;

   typedef struct {
      pts_pkg::char_type ch;
      logic [31:0]       uid;
   } path_item_t;

   typedef struct packed {
      logic [pts_pkg::SCORE_W-1:0] score;
      logic                        sens;
      logic                        script;
      logic                        temp;
   } verdict_t;

   // -------------------------------------------------------------------------
   // Clock, reset and the signals to and from the scorer. Every input starts
   // at a known value so that nothing floats before the first edge.
   // -------------------------------------------------------------------------
   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   pts_pkg::char_type             req_path_byte = '0;
   logic [31:0]                   req_caller_uid = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [pts_pkg::SCORE_W-1:0]   rsp_threat_score;
   logic                          rsp_sensitive_hit;
   logic                          rsp_script_hit;
   logic                          rsp_temp_dir_hit;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [pts_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [pts_pkg::WEIGHT_W-1:0]  csr_wdata = '0;

   always #HALF_PERIOD clock = ~clock;

   path_threat_scorer u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_path_byte     (req_path_byte),
      .req_caller_uid    (req_caller_uid),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_threat_score  (rsp_threat_score),
      .rsp_sensitive_hit (rsp_sensitive_hit),
      .rsp_script_hit    (rsp_script_hit),
      .rsp_temp_dir_hit  (rsp_temp_dir_hit),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // -------------------------------------------------------------------------
   // Scoring model. It holds its own copy of the weights, the byte window
   // (newest byte in the last element) and the three sticky group flags.
   // -------------------------------------------------------------------------
   string threat_text [pts_pkg::PAT_NUM] = '{
      "/etc/passwd", "/etc/shadow", "/etc/sudoers", "/root/", "/proc/", "/sys/",
      ".sh", ".py", ".pl", "/tmp/", "/var/tmp/"
   };
   pts_pkg::grp_type threat_group [pts_pkg::PAT_NUM] = '{
      pts_pkg::GRP_SENS, pts_pkg::GRP_SENS, pts_pkg::GRP_SENS,
      pts_pkg::GRP_SENS, pts_pkg::GRP_SENS, pts_pkg::GRP_SENS,
      pts_pkg::GRP_SCRIPT, pts_pkg::GRP_SCRIPT, pts_pkg::GRP_SCRIPT,
      pts_pkg::GRP_TEMP, pts_pkg::GRP_TEMP
   };

   logic [pts_pkg::WEIGHT_W-1:0] w_sens   = pts_pkg::SENSITIVE_WEIGHT_RST;
   logic [pts_pkg::WEIGHT_W-1:0] w_root   = pts_pkg::ROOT_WEIGHT_RST;
   logic [pts_pkg::WEIGHT_W-1:0] w_script = pts_pkg::SCRIPT_WEIGHT_RST;
   logic [pts_pkg::WEIGHT_W-1:0] w_temp   = pts_pkg::TEMP_DIR_WEIGHT_RST;

   pts_pkg::char_type window [TAIL_LEN] = '{default: '0};
   int       path_len    = 0;
   bit       seen_sens   = 1'b0;
   bit       seen_script = 1'b0;
   bit       seen_temp   = 1'b0;

   // Scores still owed by the scorer, oldest first.
   verdict_t   expected_verdicts [$];
   // Path bytes waiting for the driver.
   path_item_t pending_bytes [$];

   int fault_count   = 0;
   int send_gap_pct  = 0;
   int rsp_stall_pct = 0;
   int hold_go       = 0;
   int hold_seen     = 0;
   int hold_left     = 0;
   int cycle_count   = 0;

   task automatic log_fault(input string msg);
      fault_count++;
      if (fault_count <= 10) begin
         $display("%s", msg);
      end
   endtask

   // Advances the model by one accepted item. Non-zero bytes only move the
   // window; a zero byte closes the path and yields exactly one score.
   task automatic absorb_item(input pts_pkg::char_type ch, input logic [31:0] uid);
      verdict_t v;
      int       n;
      int       sum;
      bit       hit;
      if (ch != 8'h00) begin
         // Bytes past the truncation point are dropped without effect.
         if (path_len < PATH_LIMIT - 1) begin
            for (int i = 0; i < TAIL_LEN - 1; i++) begin
               window[i] = window[i + 1];
            end
            window[TAIL_LEN - 1] = ch;
            path_len++;
            for (int p = 0; p < pts_pkg::PAT_NUM; p++) begin
               n = threat_text[p].len();
               if (n <= path_len) begin
                  hit = 1'b1;
                  for (int i = 0; i < n; i++) begin
                     if (window[TAIL_LEN - n + i] != threat_text[p][i]) begin
                        hit = 1'b0;
                     end
                  end
                  if (hit) begin
                     case (threat_group[p])
                        pts_pkg::GRP_SENS:   seen_sens   = 1'b1;
                        pts_pkg::GRP_SCRIPT: seen_script = 1'b1;
                        default:             seen_temp   = 1'b1;
                     endcase
                  end
               end
            end
         end
      end else begin
         sum = 0;
         if (seen_sens)   sum += w_sens;
         if (uid == 0)    sum += w_root;
         if (seen_script) sum += w_script;
         if (seen_temp)   sum += w_temp;
         v.score  = sum[pts_pkg::SCORE_W-1:0];
         v.sens   = seen_sens;
         v.script = seen_script;
         v.temp   = seen_temp;
         expected_verdicts.push_back(v);
         // The window is wiped so that no pattern can reach into the next path.
         window      = '{default: '0};
         path_len    = 0;
         seen_sens   = 1'b0;
         seen_script = 1'b0;
         seen_temp   = 1'b0;
      end
   endtask

   // -------------------------------------------------------------------------
   // Request driver. The model is advanced at the very edge on which the
   // scorer takes an item, using the payload that was on the port before the
   // edge. A new item is only presented once the previous one has gone, and
   // the valid line receives at most one assignment per edge.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : drive_req
      path_item_t nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            absorb_item(req_path_byte, req_caller_uid);
         end
         if (!req_valid || req_ready) begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
               nxt = pending_bytes.pop_front();
               req_path_byte  <= nxt.ch;
               req_caller_uid <= nxt.uid;
               req_valid      <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // The long hold-off runs in its own process. The stimulus asks for one by
   // bumping hold_go; the timer then loads LONG_HOLD and counts down to zero.
   always @(posedge clock) begin : hold_timer
      if (hold_go != hold_seen) begin
         hold_seen <= hold_go;
         hold_left <= LONG_HOLD;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // -------------------------------------------------------------------------
   // Response monitor. Each accepted score is checked field by field against
   // the oldest one the model expects; ready is then re-rolled for the next
   // cycle according to the stall rate and any hold-off in progress.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : take_rsp
      verdict_t got;
      verdict_t want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_threat_score, rsp_sensitive_hit, rsp_script_hit, rsp_temp_dir_hit};
            if (expected_verdicts.size() == 0) begin
               log_fault($sformatf("tb_top: score %0d arrived with none outstanding",
                                   got.score));
            end else begin
               want = expected_verdicts.pop_front();
               if (got.score !== want.score || got.sens !== want.sens ||
                   got.script !== want.script || got.temp !== want.temp) begin
                  log_fault($sformatf({"tb_top: mismatch: expected score %0d s/c/t %b%b%b,",
                                       " got score %0d s/c/t %b%b%b"},
                                      want.score, want.sens, want.script, want.temp,
                                      got.score, got.sens, got.script, got.temp));
               end
            end
         end
         rsp_ready <= (hold_left == 0) && ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // A watchdog in case the scorer locks up or loses a score.
   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers.
   // -------------------------------------------------------------------------

   // Queues the bytes of one path followed by its terminator. Only the uid on
   // the terminator matters, so the others are random.
   task automatic queue_path(input pts_pkg::char_type body [$], input logic [31:0] uid);
      foreach (body[i]) begin
         pending_bytes.push_back('{body[i], $urandom()});
      end
      pending_bytes.push_back('{8'h00, uid});
   endtask

   task automatic append_text(ref pts_pkg::char_type body [$], input string s);
      for (int i = 0; i < s.len(); i++) begin
         body.push_back(s[i]);
      end
   endtask

   task automatic queue_text(input string s, input logic [31:0] uid);
      pts_pkg::char_type body [$];
      append_text(body, s);
      queue_path(body, uid);
   endtask

   function automatic logic [31:0] pick_uid();
      case ($urandom_range(9))
         0, 1, 2: return 32'h0;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   // Most paths are strung together from whole patterns, cut-off patterns,
   // directory names and odd bytes; one in ten is plain byte noise.
   task automatic build_random_path(ref pts_pkg::char_type body [$]);
      string s;
      body = {};
      if ($urandom_range(9) == 0) begin
         repeat ($urandom_range(0, 20)) body.push_back(8'($urandom_range(1, 255)));
      end else begin
         repeat ($urandom_range(0, 5)) begin
            case ($urandom_range(9))
               0, 1, 2, 3: append_text(body, threat_text[$urandom_range(0, 10)]);
               4: begin
                  s = threat_text[$urandom_range(0, 10)];
                  append_text(body, s.substr(0, $urandom_range(0, s.len() - 2)));
               end
               5: begin
                  body.push_back("/");
                  repeat ($urandom_range(1, 4)) begin
                     body.push_back(8'(8'h61 + $urandom_range(0, 25)));
                  end
               end
               6: repeat ($urandom_range(1, 3)) body.push_back(8'($urandom_range(1, 255)));
               default: repeat ($urandom_range(1, 4)) begin
                  body.push_back(8'(8'h61 + $urandom_range(0, 25)));
               end
            endcase
         end
      end
   endtask

   // A path well past the truncation point. A pattern is planted either so
   // that its last byte is the last byte still matched, or so that it runs
   // over the cut; a temporary directory lies wholly in the ignored tail.
   task automatic build_long_path(ref pts_pkg::char_type body [$]);
      string pat;
      string tail_pat;
      int    at;
      body = {};
      repeat (LONG_LEN) body.push_back(8'(8'h61 + $urandom_range(0, 25)));
      pat = threat_text[$urandom_range(0, 10)];
      if ($urandom_range(1) != 0) begin
         at = PATH_LIMIT - 1 - pat.len();
      end else begin
         at = PATH_LIMIT - 3;
      end
      for (int i = 0; i < pat.len(); i++) begin
         body[at + i] = pat[i];
      end
      tail_pat = "/tmp/";
      for (int i = 0; i < tail_pat.len(); i++) begin
         body[TAIL_AT + i] = tail_pat[i];
      end
   endtask

   // Queues random paths until roughly budget items, terminators included,
   // have been queued, optionally opening with one long path.
   task automatic random_paths(input int budget, input bit with_long);
      pts_pkg::char_type body [$];
      int       counted;
      counted = 0;
      if (with_long) begin
         build_long_path(body);
         queue_path(body, pick_uid());
         counted += body.size() + 1;
      end
      while (counted < budget) begin
         build_random_path(body);
         queue_path(body, pick_uid());
         counted += body.size() + 1;
      end
   endtask

   // Waits until every byte has been taken and every score has come back,
   // then lets the scorer settle.
   task automatic settle();
      do @(posedge clock);
      while (pending_bytes.size() != 0 || req_valid || expected_verdicts.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One register write. The model picks up the new weight once the scorer
   // has taken it; unknown indexes leave every weight alone.
   task automatic write_weight(input logic [pts_pkg::CSR_IDX_W-1:0] idx,
                               input logic [pts_pkg::WEIGHT_W-1:0] val);
      @(posedge clock);
      csr_index <= idx;
      csr_wdata <= val;
      csr_valid <= 1'b1;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         pts_pkg::REG_SENSITIVE_WEIGHT: w_sens   = val;
         pts_pkg::REG_ROOT_WEIGHT:      w_root   = val;
         pts_pkg::REG_SCRIPT_WEIGHT:    w_script = val;
         pts_pkg::REG_TEMP_DIR_WEIGHT:  w_temp   = val;
         default: ;
      endcase
   endtask

   task automatic write_all(input logic [pts_pkg::WEIGHT_W-1:0] sens,
                            input logic [pts_pkg::WEIGHT_W-1:0] root,
                            input logic [pts_pkg::WEIGHT_W-1:0] script,
                            input logic [pts_pkg::WEIGHT_W-1:0] temp);
      write_weight(pts_pkg::REG_SENSITIVE_WEIGHT, sens);
      write_weight(pts_pkg::REG_ROOT_WEIGHT, root);
      write_weight(pts_pkg::REG_SCRIPT_WEIGHT, script);
      write_weight(pts_pkg::REG_TEMP_DIR_WEIGHT, temp);
   endtask

   // -------------------------------------------------------------------------
   // Test sequence. Weights only change between phases, once the scorer has
   // returned everything it owes.
   // -------------------------------------------------------------------------
   initial begin : stimulus
      pts_pkg::char_type odd_bytes [$];

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Phase one: reset weights, no idling. The directed paths cover an
      // empty path for root and for the top uid, the one pattern that fills
      // the whole window, two groups at once, a pattern split across
      // two paths (which must not match) and bytes with the top bit set.
      queue_text("", 32'h0);
      queue_text("", 32'hFFFF_FFFF);
      queue_text("/etc/sudoers", 32'h0);
      queue_text("/var/tmp/a.pl", 32'h1);
      queue_text("/ro", 32'h0);
      queue_text("ot/", 32'h5);
      odd_bytes = '{8'hFF, 8'h80};
      queue_path(odd_bytes, 32'h8000_0000);
      random_paths(50, 1'b0);
      settle();

      // Phase two: every weight at its top value; the sender idles half the
      // time. A write to an index with every bit set must be ignored. The
      // phase opens with the one long path of the run.
      write_all(7'd127, 7'd127, 7'd127, 7'd127);
      write_weight(REG_UNUSED_ALL, 7'd0);
      send_gap_pct = 50;
      random_paths(310, 1'b1);
      settle();

      // Phase three: every weight zero, the receiver stalls half the time.
      write_all(7'd0, 7'd0, 7'd0, 7'd0);
      write_weight(REG_UNUSED_LOW, 7'd127);
      send_gap_pct  = 0;
      rsp_stall_pct = 50;
      random_paths(50, 1'b0);
      settle();

      // Phase four: random weights, light idling on both sides.
      write_all(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
      send_gap_pct  = 9;
      rsp_stall_pct = 9;
      random_paths(50, 1'b0);
      settle();

      // Phase five: the receiver holds off for a long stretch while the sender
      // keeps offering bytes, so the held score backs up into the input.
      write_all(7'd127, 7'd0, 7'd1, 7'd64);
      send_gap_pct  = 0;
      rsp_stall_pct = 0;
      hold_go++;
      repeat (2) @(posedge clock);
      random_paths(40, 1'b0);
      settle();

      // Phase six: fresh random weights, no idling at all.
      write_all(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
      random_paths(30, 1'b0);
      settle();

      if (expected_verdicts.size() != 0) begin
         log_fault($sformatf("tb_top: %0d scores never arrived", expected_verdicts.size()));
      end
      if (fault_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
